@@ hdl/bdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debouncer with long-press events.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

	localparam int NUM_BUTTONS_DEF = 8;
	// button_index is 3 bits wide, so at most this many counters are reachable
	localparam int MAX_BUTTONS     = 8;

	localparam int IDX_W  = 3;
	localparam int CNT_W  = 8;
	localparam int KIND_W = 2;
	localparam int ID_W   = 4;
	localparam int REG_W  = 2;
	localparam int DATA_W = 8;

	localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd2;
	localparam logic [CNT_W-1:0] LONG_RST     = 8'd200;
	localparam logic [CNT_W-1:0] MASK_RST     = 8'd0;

	typedef enum logic [KIND_W-1:0] {
		EV_PRESS   = 2'd0,
		EV_LONG    = 2'd1,
		EV_RELEASE = 2'd2
	} ev_kind_t;

	typedef enum logic [REG_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_MASK     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] debounce;
		logic [CNT_W-1:0] long_cnt;
		logic [CNT_W-1:0] mask;
	} cfg_t;

	typedef struct packed {
		logic            valid;
		ev_kind_t        kind;
		logic [ID_W-1:0] id;
	} ev_t;

endpackage

`default_nettype wire

@@ hdl/bdlp_ifs.sv @@
// ----------------------------------------------------------------------------
// bdlp channel interfaces
// Valid/ready channels for samples, events and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdlp_sample_if;
	logic       valid;
	logic       ready;
	logic [2:0] button_index;
	logic       pin_level;

	modport source (output valid, button_index, pin_level, input ready);
	modport sink   (input valid, button_index, pin_level, output ready);
endinterface

interface bdlp_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [3:0] button_id;

	modport source (output valid, event_kind, button_id, input ready);
	modport sink   (input valid, event_kind, button_id, output ready);
endinterface

interface bdlp_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] reg_index;
	logic [7:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

@@ hdl/button_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounces periodic button samples and reports press, long-press and
// release events per button.
// ----------------------------------------------------------------------------
//  channel   dir   payload                      handshake
//  samples   in    button_index[2:0] pin_level  valid/ready
//  events    out   event_kind[1:0] button_id    valid/ready
//  cfg       in    reg_index[1:0] wdata[7:0]    valid/ready, always ready
//
//  One sample per cycle sustained unless a stalled event output holds it; an
//  event passes the sample register, then the event register, to the port.
//  The counter read-modify-write happens in the sample register's cycle, so
//  back-to-back samples of one button see the updated count.
//  Reset clears all counters and loads debounce 2, long 200, mask 0.
//  A stalled event output holds the sample register only when it has an event.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press #(
	parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	bdlp_sample_if.sink     samples,
	bdlp_event_if.source    events,
	bdlp_cfg_if.sink        cfg
);
	import bdlp_pkg::*;

	cfg_t             cfg_q;
	logic             s1_valid;
	logic [IDX_W-1:0] s1_idx;
	logic             s1_level;
	logic             s1_go;
	ev_t              ev;
	logic             out_valid_q;
	ev_kind_t         out_kind_q;
	logic [ID_W-1:0]  out_id_q;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce <= DEBOUNCE_RST;
			cfg_q.long_cnt <= LONG_RST;
			cfg_q.mask     <= MASK_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.reg_index))
				REG_DEBOUNCE: cfg_q.debounce <= cfg.wdata;
				REG_LONG:     cfg_q.long_cnt <= cfg.wdata;
				REG_MASK:     cfg_q.mask     <= cfg.wdata;
				default:      ;
			endcase
		end
	end

	bdlp_cnt_bank #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_cnt_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (s1_go),
		.idx    (s1_idx),
		.level  (s1_level),
		.cfg    (cfg_q),
		.ev     (ev)
	);

	assign s1_go         = s1_valid && (!out_valid_q || events.ready || !ev.valid);
	assign samples.ready = !s1_valid || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (samples.ready) begin
			s1_valid <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			s1_idx   <= samples.button_index;
			s1_level <= samples.pin_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && ev.valid) begin
			out_valid_q <= 1'b1;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && ev.valid) begin
			out_kind_q <= ev.kind;
			out_id_q   <= ev.id;
		end
	end

	assign events.valid      = out_valid_q;
	assign events.event_kind = out_kind_q;
	assign events.button_id  = out_id_q;

	// an event never overwrites one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && ev.valid |-> !out_valid_q || events.ready)
		else $error("event register overwritten");

	// a held sample register keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_go |=> s1_valid && $stable(s1_idx) && $stable(s1_level))
		else $error("stalled sample lost");

	// every event register load shows up on the port next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && ev.valid |=> out_valid_q && out_id_q != 4'd0)
		else $error("event not presented");

endmodule

`default_nettype wire

@@ hdl/bdlp_cnt_bank.sv @@
// ----------------------------------------------------------------------------
// bdlp_cnt_bank
// Per-button press counters with the read-modify-write that yields events.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_cnt_bank #(
	parameter int NUM_BUTTONS = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      upd,
	input  wire logic [bdlp_pkg::IDX_W-1:0] idx,
	input  wire logic                      level,
	input  wire bdlp_pkg::cfg_t            cfg,
	output bdlp_pkg::ev_t                  ev
);
	import bdlp_pkg::*;

	localparam int CntDepth = (NUM_BUTTONS < MAX_BUTTONS) ? NUM_BUTTONS : MAX_BUTTONS;
	localparam int CntIdxW  = (CntDepth > 1) ? $clog2(CntDepth) : 1;
	localparam logic [6:0] NumB = 7'(NUM_BUTTONS);

	logic [CNT_W-1:0] cnt_q [CntDepth];

	logic             in_rng;
	logic             active;
	logic [CNT_W-1:0] cur;
	logic [CNT_W:0]   nxt9;
	logic [CNT_W-1:0] cnt_d;
	logic             cnt_we;

	assign in_rng = {4'b0, idx} < NumB;
	assign active = cfg.mask[idx];
	assign cur    = in_rng ? cnt_q[idx[CntIdxW-1:0]] : '0;
	assign nxt9   = {1'b0, cur} + 9'd1;

	always_comb begin
		ev.valid = 1'b0;
		ev.kind  = EV_PRESS;
		ev.id    = {1'b0, idx} + 4'd1;
		cnt_d    = cur;
		cnt_we   = 1'b0;
		if (in_rng) begin
			if (level == active) begin
				cnt_we = 1'b1;
				if (nxt9 > {1'b0, cfg.long_cnt}) begin
					// saturate at the long count, no event
					cnt_d = cfg.long_cnt;
				end else begin
					cnt_d = nxt9[CNT_W-1:0];
					if (nxt9[CNT_W-1:0] == cfg.long_cnt) begin
						ev.valid = 1'b1;
						ev.kind  = EV_LONG;
					end else if (nxt9[CNT_W-1:0] == cfg.debounce) begin
						ev.valid = 1'b1;
						ev.kind  = EV_PRESS;
					end
				end
			end else if (cur >= cfg.debounce) begin
				cnt_we   = 1'b1;
				cnt_d    = '0;
				ev.valid = 1'b1;
				ev.kind  = EV_RELEASE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CntDepth; i++) cnt_q[i] <= '0;
		end else if (upd && cnt_we) begin
			cnt_q[idx[CntIdxW-1:0]] <= cnt_d;
		end
	end

endmodule

`default_nettype wire
